// ----- rtl/hbs_pkg.sv -----
`default_nettype none
package hbs_pkg;

    localparam int GRID_BITS       = 8;
    localparam int COORD_FRAC_BITS = 8;

    localparam int H_W      = 24;
    localparam int DIM_W    = GRID_BITS + 1;
    localparam int CELL_W   = 10;
    localparam int CMP_W    = ((DIM_W > CELL_W) ? DIM_W : CELL_W) + 1;
    localparam int QRY_W    = 26;
    localparam int FRAC_W   = COORD_FRAC_BITS + 1;
    localparam int SCALE    = 1 << COORD_FRAC_BITS;
    localparam int COEF_W   = 16;
    localparam int COEF_ONE = 32768;
    localparam int PROD_W   = 42;
    localparam int GND_W    = 45;
    localparam int TOP_W    = H_W + COORD_FRAC_BITS + 2;
    localparam int ACC_W    = H_W + 2 * COORD_FRAC_BITS + 2;
    localparam int H_MAX    = 8388607;
    localparam int H_MIN    = -8388608;

    localparam int NUM_BANKS  = 4;
    localparam int BANK_AW    = 2 * GRID_BITS - 2;
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int ENTRY_W    = 2 * H_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int OUT_DEPTH   = 8;
    localparam int OPTR_W      = 3;

    localparam int S_TDATA_W = 184;
    localparam int M_TDATA_W = 24;
    localparam int TUSER_W   = 2;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_GROUND = 2'd1,
        OP_FULL   = 2'd2,
        OP_POINT  = 2'd3
    } op_t;

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } grid_dims_t;

    typedef struct packed {
        op_t                        op;
        logic                       wr_en;
        logic [GRID_BITS-1:0]       x0;
        logic [GRID_BITS-1:0]       y0;
        logic [FRAC_W-1:0]          dx;
        logic [FRAC_W-1:0]          dy;
        logic signed [PROD_W-1:0]   p_base;
        logic signed [PROD_W-1:0]   p_add;
        logic signed [H_W-1:0]      river;
        logic signed [H_W-1:0]      extra;
    } q_entry_t;

endpackage
`default_nettype wire

// ----- rtl/hbs_front.sv -----
`default_nettype none
module hbs_front (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire  hbs_pkg::grid_dims_t            dims,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [hbs_pkg::S_TDATA_W-1:0]        s_tdata,
    input  wire  [hbs_pkg::TUSER_W-1:0]          s_tuser,
    output logic                                 q_valid,
    input  wire                                  q_ready,
    output hbs_pkg::q_entry_t                    q_data
);

    logic                       valid_reg;
    hbs_pkg::q_entry_t          entry_reg;
    hbs_pkg::q_entry_t          entry_next;

    logic signed [hbs_pkg::CELL_W-1:0] cell_x, cell_y;
    logic signed [hbs_pkg::H_W-1:0]    base_h, add_h, river_h, extra_h, qx, qy;
    logic [hbs_pkg::COEF_W-1:0]        coeff, c_sat;
    logic signed [17:0]                c_wgt;

    logic signed [hbs_pkg::CMP_W-1:0]  cxs, cys, ws, hs;
    logic                              in_grid;
    logic [hbs_pkg::GRID_BITS-1:0]     px, py;

    logic signed [hbs_pkg::QRY_W-1:0]  qxe, qye, flx, fly, w2, h2, cxq, cyq, dxf, dyf;
    logic [hbs_pkg::FRAC_W-1:0]        dx, dy;

    assign cell_x  = s_tdata[9:0];
    assign cell_y  = s_tdata[19:10];
    assign base_h  = s_tdata[43:20];
    assign coeff   = s_tdata[59:44];
    assign add_h   = s_tdata[83:60];
    assign river_h = s_tdata[107:84];
    assign extra_h = s_tdata[131:108];
    assign qx      = s_tdata[155:132];
    assign qy      = s_tdata[179:156];

    always_comb begin
        // ground products: base*c and add*(1 - 2c), c saturated at one
        c_sat = (coeff > hbs_pkg::COEF_W'(hbs_pkg::COEF_ONE)) ?
                hbs_pkg::COEF_W'(hbs_pkg::COEF_ONE) : coeff;
        c_wgt = $signed(18'(hbs_pkg::COEF_ONE)) - $signed({1'b0, c_sat, 1'b0});

        // write bounds and point clamp
        cxs = hbs_pkg::CMP_W'(cell_x);
        cys = hbs_pkg::CMP_W'(cell_y);
        ws  = $signed(hbs_pkg::CMP_W'(dims.width));
        hs  = $signed(hbs_pkg::CMP_W'(dims.height));
        in_grid = (cxs >= 0) && (cxs < ws) && (cys >= 0) && (cys < hs);
        if (cxs < 0)            px = '0;
        else if (cxs > ws - 1)  px = hbs_pkg::GRID_BITS'(ws - 1);
        else                    px = hbs_pkg::GRID_BITS'(cxs);
        if (cys < 0)            py = '0;
        else if (cys > hs - 1)  py = hbs_pkg::GRID_BITS'(hs - 1);
        else                    py = hbs_pkg::GRID_BITS'(cys);

        // query cell and fraction
        qxe = hbs_pkg::QRY_W'(qx);
        qye = hbs_pkg::QRY_W'(qy);
        flx = qxe >>> hbs_pkg::COORD_FRAC_BITS;
        fly = qye >>> hbs_pkg::COORD_FRAC_BITS;
        w2  = $signed(hbs_pkg::QRY_W'(dims.width)) - 2;
        h2  = $signed(hbs_pkg::QRY_W'(dims.height)) - 2;
        if (flx < 0)        cxq = '0;
        else if (flx > w2)  cxq = w2;
        else                cxq = flx;
        if (fly < 0)        cyq = '0;
        else if (fly > h2)  cyq = h2;
        else                cyq = fly;
        dxf = qxe - (cxq <<< hbs_pkg::COORD_FRAC_BITS);
        dyf = qye - (cyq <<< hbs_pkg::COORD_FRAC_BITS);
        if (dxf < 0)                                   dx = '0;
        else if (dxf > hbs_pkg::QRY_W'(hbs_pkg::SCALE)) dx = hbs_pkg::FRAC_W'(hbs_pkg::SCALE);
        else                                           dx = hbs_pkg::FRAC_W'(dxf);
        if (dyf < 0)                                   dy = '0;
        else if (dyf > hbs_pkg::QRY_W'(hbs_pkg::SCALE)) dy = hbs_pkg::FRAC_W'(hbs_pkg::SCALE);
        else                                           dy = hbs_pkg::FRAC_W'(dyf);

        entry_next        = '0;
        entry_next.op     = hbs_pkg::op_t'(s_tuser[1:0]);
        entry_next.dx     = dx;
        entry_next.dy     = dy;
        entry_next.p_base = base_h * $signed({1'b0, c_sat});
        entry_next.p_add  = add_h * c_wgt;
        entry_next.river  = river_h;
        entry_next.extra  = extra_h;
        case (entry_next.op)
            hbs_pkg::OP_WRITE: begin
                entry_next.wr_en = in_grid;
                entry_next.x0    = cell_x[hbs_pkg::GRID_BITS-1:0];
                entry_next.y0    = cell_y[hbs_pkg::GRID_BITS-1:0];
            end
            hbs_pkg::OP_POINT: begin
                entry_next.x0 = px;
                entry_next.y0 = py;
            end
            default: begin
                entry_next.x0 = hbs_pkg::GRID_BITS'(cxq);
                entry_next.y0 = hbs_pkg::GRID_BITS'(cyq);
            end
        endcase
    end

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_data   = entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            entry_reg <= entry_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hbs_queue.sv -----
`default_nettype none
module hbs_queue (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire  hbs_pkg::q_entry_t  in_data,
    output logic                     out_valid,
    input  wire                      out_pop,
    output hbs_pkg::q_entry_t        out_data
);

    hbs_pkg::q_entry_t              mem_reg [hbs_pkg::QUEUE_DEPTH];
    logic [hbs_pkg::QPTR_W-1:0]     wptr_reg, rptr_reg;
    logic [hbs_pkg::QPTR_W:0]       count_reg, count_next;
    logic                           push;

    assign in_ready  = count_reg < (hbs_pkg::QPTR_W+1)'(hbs_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !out_pop)      count_next = count_reg + 1'b1;
        else if (!push && out_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push)    wptr_reg <= wptr_reg + 1'b1;
            if (out_pop) rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hbs_back.sv -----
`default_nettype none
module hbs_back (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              q_valid,
    input  wire  hbs_pkg::q_entry_t          q_data,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [hbs_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [hbs_pkg::TUSER_W-1:0]      m_tuser
);

    localparam int GB  = hbs_pkg::GRID_BITS;
    localparam int HW  = hbs_pkg::H_W;
    localparam int OW  = hbs_pkg::OPTR_W;

    // ---- stage 1: ground/full finalize ----
    logic signed [hbs_pkg::GND_W-1:0] sum, gnd_raw, full_raw;
    logic [HW-1:0]                    ground_next, full_next;

    logic                 s1_valid_reg, s1_wr_reg;
    hbs_pkg::op_t         s1_op_reg;
    logic [GB-1:0]        s1_x0_reg, s1_y0_reg;
    logic [hbs_pkg::FRAC_W-1:0] s1_dx_reg, s1_dy_reg;
    logic [HW-1:0]        s1_ground_reg, s1_full_reg;

    always_comb begin
        sum = hbs_pkg::GND_W'(q_data.p_base) + hbs_pkg::GND_W'(q_data.p_add)
            + hbs_pkg::GND_W'(1 << 14);
        gnd_raw = (sum >>> 15) + hbs_pkg::GND_W'(q_data.river);
        if (gnd_raw < 0)
            ground_next = '0;
        else if (gnd_raw > hbs_pkg::GND_W'(hbs_pkg::H_MAX))
            ground_next = HW'(hbs_pkg::H_MAX);
        else
            ground_next = HW'(gnd_raw);
        full_raw = hbs_pkg::GND_W'($signed(ground_next)) + hbs_pkg::GND_W'(q_data.extra);
        if (full_raw < hbs_pkg::GND_W'(hbs_pkg::H_MIN))
            full_next = HW'(hbs_pkg::H_MIN);
        else if (full_raw > hbs_pkg::GND_W'(hbs_pkg::H_MAX))
            full_next = HW'(hbs_pkg::H_MAX);
        else
            full_next = HW'(full_raw);
    end

    // ---- banked store: bank = {y[0], x[0]}, one read per bank per cycle ----
    logic [hbs_pkg::ENTRY_W-1:0] mem [hbs_pkg::NUM_BANKS][hbs_pkg::BANK_DEPTH];
    logic [hbs_pkg::BANK_AW-1:0] ridx [hbs_pkg::NUM_BANKS];
    logic [hbs_pkg::BANK_AW-1:0] widx;
    logic [1:0]                  wbank;
    logic [GB-1:0]               x1, y1, xb, yb;

    always_comb begin
        x1    = s1_x0_reg + 1'b1;
        y1    = s1_y0_reg + 1'b1;
        widx  = {s1_y0_reg[GB-1:1], s1_x0_reg[GB-1:1]};
        wbank = {s1_y0_reg[0], s1_x0_reg[0]};
        for (int b = 0; b < hbs_pkg::NUM_BANKS; b++) begin
            xb = (s1_x0_reg[0] == b[0]) ? s1_x0_reg : x1;
            yb = (s1_y0_reg[0] == b[1]) ? s1_y0_reg : y1;
            ridx[b] = {yb[GB-1:1], xb[GB-1:1]};
        end
    end

    // ---- stage 2: read data ----
    logic                        s2_valid_reg;
    hbs_pkg::op_t                s2_op_reg;
    logic                        s2_xp_reg, s2_yp_reg;
    logic [hbs_pkg::FRAC_W-1:0]  s2_dx_reg, s2_dy_reg;
    logic [HW-1:0]               s2_ground_reg;
    logic [hbs_pkg::ENTRY_W-1:0] s2_rd_reg [hbs_pkg::NUM_BANKS];

    always_ff @(posedge aclk) begin
        for (int b = 0; b < hbs_pkg::NUM_BANKS; b++) begin
            if (s1_valid_reg && s1_wr_reg && (wbank == 2'(b))) begin
                mem[b][widx] <= {s1_full_reg, s1_ground_reg};
            end
            s2_rd_reg[b] <= mem[b][ridx[b]];
        end
    end

    // ---- stage 3: horizontal blend ----
    logic signed [HW-1:0]          h [hbs_pkg::NUM_BANKS];
    logic [1:0]                    i1, i2, i3, i4;
    logic [hbs_pkg::FRAC_W-1:0]    wdx, wdy;
    logic signed [hbs_pkg::TOP_W-1:0] top_next, bot_next;
    logic [HW-1:0]                 direct_next;

    always_comb begin
        for (int b = 0; b < hbs_pkg::NUM_BANKS; b++) begin
            h[b] = (s2_op_reg == hbs_pkg::OP_GROUND) ? s2_rd_reg[b][HW-1:0]
                                                     : s2_rd_reg[b][2*HW-1:HW];
        end
        i1  = {s2_yp_reg, s2_xp_reg};
        i2  = {s2_yp_reg, !s2_xp_reg};
        i3  = {!s2_yp_reg, s2_xp_reg};
        i4  = {!s2_yp_reg, !s2_xp_reg};
        wdx = hbs_pkg::FRAC_W'(hbs_pkg::SCALE) - s2_dx_reg;
        top_next = h[i1] * $signed({1'b0, wdx}) + h[i2] * $signed({1'b0, s2_dx_reg});
        bot_next = h[i3] * $signed({1'b0, wdx}) + h[i4] * $signed({1'b0, s2_dx_reg});
        direct_next = (s2_op_reg == hbs_pkg::OP_WRITE) ? s2_ground_reg : h[i1];
    end

    logic                          s3_valid_reg;
    hbs_pkg::op_t                  s3_op_reg;
    logic signed [hbs_pkg::TOP_W-1:0] s3_top_reg, s3_bot_reg;
    logic [hbs_pkg::FRAC_W-1:0]    s3_dy_reg;
    logic [HW-1:0]                 s3_direct_reg;

    // ---- stage 4: vertical blend ----
    logic signed [hbs_pkg::ACC_W-1:0] acc_next;
    always_comb begin
        wdy = hbs_pkg::FRAC_W'(hbs_pkg::SCALE) - s3_dy_reg;
        acc_next = s3_top_reg * $signed({1'b0, wdy}) + s3_bot_reg * $signed({1'b0, s3_dy_reg});
    end

    logic                          s4_valid_reg;
    hbs_pkg::op_t                  s4_op_reg;
    logic signed [hbs_pkg::ACC_W-1:0] s4_acc_reg;
    logic [HW-1:0]                 s4_direct_reg;

    // ---- round, saturate, select ----
    logic signed [hbs_pkg::ACC_W-1:0] rnd;
    logic [HW-1:0]                    height_next;
    always_comb begin
        rnd = (s4_acc_reg + (hbs_pkg::ACC_W'(1) <<< (2 * hbs_pkg::COORD_FRAC_BITS - 1)))
              >>> (2 * hbs_pkg::COORD_FRAC_BITS);
        if ((s4_op_reg == hbs_pkg::OP_GROUND) || (s4_op_reg == hbs_pkg::OP_FULL)) begin
            if (rnd > hbs_pkg::ACC_W'(hbs_pkg::H_MAX))
                height_next = HW'(hbs_pkg::H_MAX);
            else if (rnd < hbs_pkg::ACC_W'(hbs_pkg::H_MIN))
                height_next = HW'(hbs_pkg::H_MIN);
            else
                height_next = HW'(rnd);
        end else begin
            height_next = s4_direct_reg;
        end
    end

    // ---- output FIFO with credit check on pop ----
    logic [HW+1:0]   ofifo_reg [hbs_pkg::OUT_DEPTH];
    logic [OW-1:0]   owptr_reg, orptr_reg;
    logic [OW:0]     ocount_reg, ocount_next;
    logic [2:0]      inflight;
    logic            opush, opop;

    assign inflight = 3'(s1_valid_reg) + 3'(s2_valid_reg) + 3'(s3_valid_reg)
                    + 3'(s4_valid_reg);
    assign q_pop    = q_valid &&
                      (5'(inflight) + 5'(ocount_reg) < 5'(hbs_pkg::OUT_DEPTH));
    assign opush    = s4_valid_reg;
    assign opop     = m_tvalid && m_tready;
    assign m_tvalid = ocount_reg != '0;
    assign m_tdata  = ofifo_reg[orptr_reg][HW-1:0];
    assign m_tuser  = ofifo_reg[orptr_reg][HW+1:HW];

    always_comb begin
        ocount_next = ocount_reg;
        if (opush && !opop)      ocount_next = ocount_reg + 1'b1;
        else if (!opush && opop) ocount_next = ocount_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            owptr_reg    <= '0;
            orptr_reg    <= '0;
            ocount_reg   <= '0;
        end else begin
            s1_valid_reg <= q_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            if (opush) owptr_reg <= owptr_reg + 1'b1;
            if (opop)  orptr_reg <= orptr_reg + 1'b1;
            ocount_reg <= ocount_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_op_reg     <= q_data.op;
        s1_wr_reg     <= q_data.wr_en;
        s1_x0_reg     <= q_data.x0;
        s1_y0_reg     <= q_data.y0;
        s1_dx_reg     <= q_data.dx;
        s1_dy_reg     <= q_data.dy;
        s1_ground_reg <= ground_next;
        s1_full_reg   <= full_next;

        s2_op_reg     <= s1_op_reg;
        s2_xp_reg     <= s1_x0_reg[0];
        s2_yp_reg     <= s1_y0_reg[0];
        s2_dx_reg     <= s1_dx_reg;
        s2_dy_reg     <= s1_dy_reg;
        s2_ground_reg <= s1_ground_reg;

        s3_op_reg     <= s2_op_reg;
        s3_top_reg    <= top_next;
        s3_bot_reg    <= bot_next;
        s3_dy_reg     <= s2_dy_reg;
        s3_direct_reg <= direct_next;

        s4_op_reg     <= s3_op_reg;
        s4_acc_reg    <= acc_next;
        s4_direct_reg <= s3_direct_reg;

        if (opush) begin
            ofifo_reg[owptr_reg] <= {s4_op_reg, height_next};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/heightmap_bilinear_sampler_core.sv -----
// Height grid sampler. Each input transaction carries an opcode in s_tuser: write one
// grid point (ground = max(base*c + add*(1-2c) + river, 0), full = ground + extra,
// both stored and the ground height returned), bilinear ground or full height at a
// Q16.8 position, or full height at a clamped integer point. Exactly one result
// transaction comes back per input, in order, with the opcode echoed in m_tuser.
// Throughput is one transaction per cycle sustained while m_tready is high: the store
// is split into four banks by x and y parity, so the four corners of any cell are
// read in the same cycle. After the accepting edge a result passes the queue write,
// four back stages and the output FIFO write before m_tvalid rises. A held-off
// m_tready backs up through the output FIFO, the queue and the front register before
// s_tready drops. A write is visible to every later transaction.
// Grid size registers (APB 0x0 width, 0x4 height) reset to 256, are clamped to
// 2..256 in use, and must only be changed while the block is idle. Grid points
// that were never written read as unknown values.
`default_nettype none
module heightmap_bilinear_sampler_core (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // tdata: cell_x[9:0], cell_y[19:10], base_height[43:20], water_coeff[59:44],
    // water_add_height[83:60], river_height[107:84], extra_height[131:108],
    // query_x[155:132], query_y[179:156], zero pad [183:180]
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [hbs_pkg::S_TDATA_W-1:0]       s_tdata,
    // tuser: opcode[1:0]
    input  wire  [hbs_pkg::TUSER_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // tdata: height[23:0]
    output logic [hbs_pkg::M_TDATA_W-1:0]       m_tdata,
    // tuser: answered_opcode[1:0]
    output logic [hbs_pkg::TUSER_W-1:0]         m_tuser,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [hbs_pkg::APB_AW-1:0]          paddr,
    input  wire  [hbs_pkg::APB_DW-1:0]          pwdata,
    output logic [hbs_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    // grid size registers, raw as written
    logic [8:0]          grid_width_reg, grid_height_reg;
    logic                cfg_wr;
    hbs_pkg::reg_idx_t   cfg_idx;
    hbs_pkg::grid_dims_t dims;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = hbs_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 9'd256;
            grid_height_reg <= 9'd256;
        end else if (cfg_wr) begin
            case (cfg_idx)
                hbs_pkg::REG_GRID_WIDTH:  grid_width_reg  <= pwdata[8:0];
                hbs_pkg::REG_GRID_HEIGHT: grid_height_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            hbs_pkg::REG_GRID_WIDTH:  prdata = {23'd0, grid_width_reg};
            hbs_pkg::REG_GRID_HEIGHT: prdata = {23'd0, grid_height_reg};
            default:                  prdata = '0;
        endcase
    end

    // sizes in use: clamp to 2..2^GRID_BITS
    always_comb begin
        if (grid_width_reg < 9'd2)
            dims.width = hbs_pkg::DIM_W'(2);
        else if (10'(grid_width_reg) > 10'(1 << hbs_pkg::GRID_BITS))
            dims.width = hbs_pkg::DIM_W'(1 << hbs_pkg::GRID_BITS);
        else
            dims.width = hbs_pkg::DIM_W'(grid_width_reg);
        if (grid_height_reg < 9'd2)
            dims.height = hbs_pkg::DIM_W'(2);
        else if (10'(grid_height_reg) > 10'(1 << hbs_pkg::GRID_BITS))
            dims.height = hbs_pkg::DIM_W'(1 << hbs_pkg::GRID_BITS);
        else
            dims.height = hbs_pkg::DIM_W'(grid_height_reg);
    end

    // front: decode, clamp, products -> queue -> back: store, blend, output FIFO
    logic              f_valid, f_ready, q_valid, q_pop;
    hbs_pkg::q_entry_t f_data, q_data;

    hbs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .dims     (dims),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_data   (f_data)
    );

    hbs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_data  (q_data)
    );

    hbs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire
